/* hdl/rpn_stack_evaluator_defines.svh */
// Assertion macros for the checker of the RPN stack evaluator.
// The macros expect signals named aclk and aresetn in the scope where they are used.
`ifndef RPN_STACK_EVALUATOR_DEFINES_SVH
`define RPN_STACK_EVALUATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RSE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/rse_pkg.sv */
// Package of the RPN stack evaluator: sizes, token and status codes, beat types
// and the command/status structs between controller and datapath. No dependencies.
package rse_pkg;

    // Sizes of the operand stack and the fixed-point format.
    localparam int STACK_DEPTH = 16;
    localparam int FRAC_BITS   = 16;
    localparam int DATA_W      = 32;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int NUM_W       = DATA_W + FRAC_BITS;
    localparam int CNT_W       = $clog2(NUM_W + 1);

    // Token codes.
    localparam logic [2:0] CMD_PUSH    = 3'd0;
    localparam logic [2:0] CMD_ADD     = 3'd1;
    localparam logic [2:0] CMD_SUB     = 3'd2;
    localparam logic [2:0] CMD_MUL     = 3'd3;
    localparam logic [2:0] CMD_DIV     = 3'd4;
    localparam logic [2:0] CMD_FINISH  = 3'd5;

    // Result status codes.
    localparam logic [2:0] STS_OK      = 3'd0;
    localparam logic [2:0] STS_FINAL   = 3'd1;
    localparam logic [2:0] STS_INVALID = 3'd2;
    localparam logic [2:0] STS_DIVZERO = 3'd3;
    localparam logic [2:0] STS_BADOP   = 3'd4;
    localparam logic [2:0] STS_FULL    = 3'd5;

    // Depth thresholds.
    localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(STACK_DEPTH);
    localparam logic [DEPTH_W-1:0] DEPTH_ONE  = DEPTH_W'(1);
    localparam logic [DEPTH_W-1:0] DEPTH_TWO  = DEPTH_W'(2);

    // One input beat.
    typedef struct packed {
        logic [2:0]               cmd;
        logic signed [DATA_W-1:0] operand;
    } in_t;

    // One result beat.
    typedef struct packed {
        logic [2:0]               status;
        logic signed [DATA_W-1:0] result_value;
        logic [DEPTH_W-1:0]       depth_now;
    } out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic read;
        logic exec;
        logic div_start;
        logic commit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_go;
        logic div_busy;
    } dp_stat_t;

endpackage

/* hdl/rse_divider.sv */
// Restoring unsigned divider, one quotient bit per cycle, for the evaluator.
// Depends on rse_pkg for NUM_W, DATA_W and CNT_W.
module rse_divider import rse_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [NUM_W-1:0]  dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              busy,
    output logic [NUM_W-1:0]  quotient
);

    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [DATA_W-1:0] div_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic              fits;

    // One restoring step: shift in the next dividend bit and try the subtraction.
    always_comb begin
        shifted  = {rem_reg, quo_reg[NUM_W-1]};
        diff     = shifted - {1'b0, div_reg};
        fits     = (shifted >= {1'b0, div_reg});
        rem_next = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
        quo_next = {quo_reg[NUM_W-2:0], fits};
    end

    // Iteration control and operand registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

/* hdl/rse_datapath.sv */
// Datapath of the evaluator: operand stack memory, depth, operand registers,
// multiplier, adder, divider and the result register. Depends on rse_pkg and rse_divider.
module rse_datapath import rse_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  in_t      s_data,
    input  dp_cmd_t  dp_cmd_i,
    output dp_stat_t dp_stat_o,
    output out_t     m_data
);

    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [63:0] WIDE_MAX = 64'(VAL_MAX);
    localparam logic signed [63:0] WIDE_MIN = 64'(VAL_MIN);
    localparam logic [NUM_W-1:0] QUO_LIM = NUM_W'({1'b1, {(DATA_W-1){1'b0}}});

    logic signed [DATA_W-1:0] mem [STACK_DEPTH];
    in_t                      tok_reg;
    logic [DEPTH_W-1:0]       depth_reg;
    logic signed [DATA_W-1:0] a_reg, b_reg;
    logic signed [63:0]       prod_reg;
    out_t                     out_reg;

    logic [DEPTH_W-1:0] top_idx, sec_idx;
    logic [PTR_W-1:0]   top_ptr, sec_ptr, push_ptr;
    logic signed [63:0] prod, prod_shift;
    logic signed [DATA_W:0] sum_w, dif_w;
    logic signed [DATA_W-1:0] add_val, sub_val, mul_val, div_val, op_val;
    logic [DATA_W-1:0]  mag_a, mag_b;
    logic [NUM_W-1:0]   quotient, quo_sat;
    logic [DATA_W-1:0]  quo_mag;
    logic               div_neg, div_busy, two_ops;

    logic [2:0]               status_n;
    logic signed [DATA_W-1:0] value_n, wr_data;
    logic [DEPTH_W-1:0]       depth_n;
    logic                     wr_en;
    logic [PTR_W-1:0]         wr_ptr;

    // Stack pointers derived from the current depth.
    assign top_idx  = depth_reg - DEPTH_ONE;
    assign sec_idx  = depth_reg - DEPTH_TWO;
    assign top_ptr  = top_idx[PTR_W-1:0];
    assign sec_ptr  = sec_idx[PTR_W-1:0];
    assign push_ptr = depth_reg[PTR_W-1:0];
    assign two_ops  = (depth_reg >= DEPTH_TWO);

    // Token capture, operand fetch and product register.
    always_ff @(posedge aclk) begin
        if (dp_cmd_i.capture) begin
            tok_reg <= s_data;
        end
        if (dp_cmd_i.read) begin
            a_reg <= mem[sec_ptr];
            b_reg <= mem[top_ptr];
        end
        if (dp_cmd_i.exec) begin
            prod_reg <= prod;
        end
    end

    // Add and subtract saturate on a sign-bit mismatch of the 33-bit result.
    always_comb begin
        sum_w   = {a_reg[DATA_W-1], a_reg} + {b_reg[DATA_W-1], b_reg};
        dif_w   = {a_reg[DATA_W-1], a_reg} - {b_reg[DATA_W-1], b_reg};
        add_val = (sum_w[DATA_W] != sum_w[DATA_W-1])
                  ? (sum_w[DATA_W] ? VAL_MIN : VAL_MAX) : sum_w[DATA_W-1:0];
        sub_val = (dif_w[DATA_W] != dif_w[DATA_W-1])
                  ? (dif_w[DATA_W] ? VAL_MIN : VAL_MAX) : dif_w[DATA_W-1:0];
    end

    // Multiply: the arithmetic shift rounds toward minus infinity, then saturate.
    assign prod       = a_reg * b_reg;
    assign prod_shift = prod_reg >>> FRAC_BITS;
    always_comb begin
        if (prod_shift > WIDE_MAX) begin
            mul_val = VAL_MAX;
        end else if (prod_shift < WIDE_MIN) begin
            mul_val = VAL_MIN;
        end else begin
            mul_val = prod_shift[DATA_W-1:0];
        end
    end

    // Divide on magnitudes; the sign is applied after the quotient is clamped.
    assign mag_a   = a_reg[DATA_W-1] ? DATA_W'(-a_reg) : DATA_W'(a_reg);
    assign mag_b   = b_reg[DATA_W-1] ? DATA_W'(-b_reg) : DATA_W'(b_reg);
    assign div_neg = a_reg[DATA_W-1] ^ b_reg[DATA_W-1];

    rse_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (dp_cmd_i.div_start),
        .dividend (NUM_W'(mag_a) << FRAC_BITS),
        .divisor  (mag_b),
        .busy     (div_busy),
        .quotient (quotient)
    );

    always_comb begin
        quo_sat = (quotient > QUO_LIM) ? QUO_LIM : quotient;
        quo_mag = quo_sat[DATA_W-1:0];
        if (div_neg) begin
            div_val = DATA_W'(-quo_mag);
        end else if (quo_mag[DATA_W-1]) begin
            div_val = VAL_MAX;
        end else begin
            div_val = quo_mag;
        end
    end

    // Select the arithmetic result of a binary operator.
    always_comb begin
        case (tok_reg.cmd)
            CMD_ADD: op_val = add_val;
            CMD_SUB: op_val = sub_val;
            CMD_MUL: op_val = mul_val;
            CMD_DIV: op_val = div_val;
            default: op_val = '0;
        endcase
    end

    // Outcome of the token: status, new depth, reported value and stack write.
    always_comb begin
        status_n = STS_OK;
        value_n  = '0;
        depth_n  = '0;
        wr_en    = 1'b0;
        wr_ptr   = sec_ptr;
        wr_data  = op_val;
        case (tok_reg.cmd)
            CMD_PUSH: begin
                if (depth_reg >= DEPTH_FULL) begin
                    status_n = STS_FULL;
                    value_n  = b_reg;
                    depth_n  = depth_reg;
                end else begin
                    wr_en    = 1'b1;
                    wr_ptr   = push_ptr;
                    wr_data  = tok_reg.operand;
                    value_n  = tok_reg.operand;
                    depth_n  = depth_reg + DEPTH_ONE;
                end
            end
            CMD_FINISH: begin
                if (depth_reg != DEPTH_ONE) begin
                    status_n = STS_INVALID;
                end else begin
                    status_n = STS_FINAL;
                    value_n  = b_reg;
                end
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                if (!two_ops) begin
                    status_n = STS_INVALID;
                end else if (tok_reg.cmd == CMD_DIV && b_reg == '0) begin
                    status_n = STS_DIVZERO;
                end else begin
                    wr_en   = 1'b1;
                    value_n = op_val;
                    depth_n = depth_reg - DEPTH_ONE;
                end
            end
            default: begin
                status_n = two_ops ? STS_BADOP : STS_INVALID;
            end
        endcase
    end

    // Stack memory write.
    always_ff @(posedge aclk) begin
        if (dp_cmd_i.commit && wr_en) begin
            mem[wr_ptr] <= wr_data;
        end
    end

    // Depth register and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
        end else if (dp_cmd_i.commit) begin
            depth_reg <= depth_n;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd_i.commit) begin
            out_reg.status       <= status_n;
            out_reg.result_value <= value_n;
            out_reg.depth_now    <= depth_n;
        end
    end

    assign dp_stat_o.div_go   = (tok_reg.cmd == CMD_DIV) && two_ops && (b_reg != '0);
    assign dp_stat_o.div_busy = div_busy;
    assign m_data             = out_reg;

endmodule

/* hdl/rse_ctrl.sv */
// Controller of the evaluator: sequences fetch, execute, divide and write back,
// and owns the handshakes. Depends on rse_pkg.
module rse_ctrl import rse_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t dp_stat_i,
    output dp_cmd_t  dp_cmd_o
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_DIVIDE,
        S_WRITE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    // The result register is free when empty or being drained this cycle.
    assign out_free = !m_valid_reg || m_ready;

    // Next state and datapath commands.
    always_comb begin
        state_next         = state_reg;
        dp_cmd_o           = '0;
        m_valid_next       = m_valid_reg && !m_ready;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    dp_cmd_o.capture = 1'b1;
                    state_next       = S_READ;
                end
            end
            S_READ: begin
                dp_cmd_o.read = 1'b1;
                state_next    = S_EXEC;
            end
            S_EXEC: begin
                dp_cmd_o.exec = 1'b1;
                if (dp_stat_i.div_go) begin
                    dp_cmd_o.div_start = 1'b1;
                    state_next         = S_DIVIDE;
                end else begin
                    state_next = S_WRITE;
                end
            end
            S_DIVIDE: begin
                if (!dp_stat_i.div_busy) begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                if (out_free) begin
                    dp_cmd_o.commit = 1'b1;
                    m_valid_next    = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

/* hdl/rpn_stack_evaluator.sv */
// Top level of the RPN stack evaluator: joins the controller and the datapath.
// Depends on rse_pkg, rse_ctrl and rse_datapath.
//
// Usage: tokens arrive on the s_ channel (s_valid/s_ready, payload s_data with cmd
// and a signed Q16.16 operand); every token produces exactly one result beat on the
// m_ channel (m_valid/m_ready, payload m_data with status, result_value, depth_now).
// The block works on one token at a time. After a token is accepted, the two top stack
// entries are fetched, the token is executed and its result is written back into the
// output register, and m_valid rises with it. A divide adds a wait in the divide state
// for the one-bit-per-cycle restoring divider over the 48-bit scaled dividend before the
// write back. s_ready is high again in the cycle in which the result beat first shows,
// so a new token can be accepted while the result still waits in the output register.
// If the receiver stalls, the next token runs up to write back and then waits there
// until the output register frees.
// Reset (aresetn low, synchronous) empties the stack and drops any pending result;
// the stack memory itself is not cleared, since entries above the depth are never used.
module rpn_stack_evaluator import rse_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    // Sequencing and handshakes.
    rse_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .dp_stat_i (dp_stat),
        .dp_cmd_o  (dp_cmd)
    );

    // Stack, arithmetic and result register.
    rse_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .dp_cmd_i  (dp_cmd),
        .dp_stat_o (dp_stat),
        .m_data    (m_data)
    );

endmodule

/* hdl/rse_checker.sv */
// Port-level checker for the RPN stack evaluator, bound to the top level.
// Depends on rse_pkg and the macros in rpn_stack_evaluator_defines.svh.
`include "rpn_stack_evaluator_defines.svh"

module rse_checker import rse_pkg::*; (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    // A stalled result beat stays put.
    `RSE_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result beat changed while stalled")

    // One token at a time: the input closes right after a beat is taken.
    `RSE_ASSERT_NEXT(a_in_busy, s_valid && s_ready, !s_ready, "input accepted a second beat while busy")

    // An error or a final result leaves the stack empty, and errors report zero.
    `RSE_ASSERT_NOW(a_err_clear, m_valid && (m_data.status == STS_INVALID || m_data.status == STS_DIVZERO || m_data.status == STS_BADOP), m_data.depth_now == '0 && m_data.result_value == '0, "error did not clear the stack")
    `RSE_ASSERT_NOW(a_final_empty, m_valid && m_data.status == STS_FINAL, m_data.depth_now == '0, "final result left operands")

    // A successful token always leaves something on a stack that fits.
    `RSE_ASSERT_NOW(a_ok_depth, m_valid && (m_data.status == STS_OK || m_data.status == STS_FULL), m_data.depth_now != '0 && m_data.depth_now <= DEPTH_FULL, "depth out of range")

endmodule

bind rpn_stack_evaluator rse_checker u_rse_checker (.*);
